// File: sv/grq_pkg.sv
package grq_pkg;

   // graph size and field widths
   localparam int NODE_COUNT  = 8;
   localparam int ROW_TOTAL   = 8;
   localparam int NODE_W      = 3;
   localparam int ROW_W       = 8;
   localparam int ROW_INDEX_W = $clog2(ROW_TOTAL);
   localparam int CSR_INDEX_W = ROW_INDEX_W + 1;
   localparam int ROUND_W     = $clog2(NODE_COUNT);

   // adjacency rows after reset: 1->2, 1->4, 2->5, 3->5, 3->6, 4->2, 5->4, 6->6
   localparam logic [ROW_W-1:0] ROW_RESET [ROW_TOTAL] =
      '{8'd0, 8'd20, 8'd32, 8'd96, 8'd4, 8'd16, 8'd64, 8'd0};

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic changed;
   } status_type;

   // true when a node code names a node of the graph
   function automatic logic node_ok(input logic [NODE_W-1:0] node);
      node_ok = (int'(node) < NODE_COUNT);
   endfunction

endpackage

// File: sv/grq_ctrl.sv
module grq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  grq_pkg::status_type  status,
   output grq_pkg::cmd_type     cmd,
   output logic                 busy
);

   typedef enum logic {
      ST_IDLE,
      ST_EXPAND
   } state_type;

   state_type                    state_ff, state_in;
   logic [grq_pkg::ROUND_W-1:0]  round_ff, round_in;
   logic                         last_round;

   // last allowed expansion round
   assign last_round = (round_ff == grq_pkg::ROUND_W'(grq_pkg::NODE_COUNT - 1));

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      round_in   = round_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               round_in = '0;
               state_in = ST_EXPAND;
            end
         end
         ST_EXPAND: begin
            cmd.step = 1'b1;
            round_in = round_ff + grq_pkg::ROUND_W'(1);
            if (!status.changed || last_round) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and round counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// File: sv/grq_datapath.sv
module grq_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  grq_pkg::cmd_type                cmd,
   output grq_pkg::status_type             status,
   input  logic [grq_pkg::NODE_W-1:0]      req_source_node,
   input  logic [grq_pkg::NODE_W-1:0]      req_target_node,
   input  logic                            csr_write,
   input  logic [grq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [grq_pkg::ROW_W-1:0]       csr_data,
   output logic                            rsp_valid,
   output logic                            rsp_reachable
);

   logic [grq_pkg::ROW_W-1:0]       adj_ff [grq_pkg::ROW_TOTAL];
   logic [grq_pkg::NODE_COUNT-1:0]  visited_ff, visited_in;
   logic [grq_pkg::NODE_COUNT-1:0]  expand;
   logic [grq_pkg::NODE_W-1:0]      target_ff;
   logic                            target_ok_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_reachable_ff;

   // adjacency rows, writes beyond the row count are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         adj_ff <= grq_pkg::ROW_RESET;
      end else if (csr_write && (int'(csr_index) < grq_pkg::ROW_TOTAL)) begin
         adj_ff[csr_index[grq_pkg::ROW_INDEX_W-1:0]] <= csr_data;
      end
   end

   // one expansion round: union of the rows of every visited node
   always_comb begin
      expand = visited_ff;
      for (int k = 0; k < grq_pkg::NODE_COUNT; k++) begin
         if (visited_ff[k]) begin
            expand = expand | adj_ff[k][grq_pkg::NODE_COUNT-1:0];
         end
      end
   end

   assign status.changed = (expand != visited_ff);

   // visited set: seeded with the source, grown one round per step
   always_comb begin
      visited_in = visited_ff;
      if (cmd.load) begin
         visited_in = '0;
         if (grq_pkg::node_ok(req_source_node)) begin
            visited_in[req_source_node] = 1'b1;
         end
      end else if (cmd.step) begin
         visited_in = expand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff <= '0;
      end else begin
         visited_ff <= visited_in;
      end
      if (cmd.load) begin
         target_ff    <= req_target_node;
         target_ok_ff <= grq_pkg::node_ok(req_target_node);
      end
   end

   // result register, shown for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
      if (cmd.finish) begin
         rsp_reachable_ff <= target_ok_ff & expand[target_ff];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_reachable = rsp_reachable_ff;

endmodule

// File: sv/graph_reachability_query.sv
// Reachability query on a directed graph of up to eight nodes. Each node has an 8-bit
// edge row written through the csr_ port (bit k set means an edge to node k); reset
// loads a six-node example graph. A transaction is taken when start is high and busy
// is low. The search then grows the visited set by one round a cycle, OR-ing the rows
// of all visited nodes, and stops when a round adds nothing or after eight rounds.
// The seed is loaded when start is taken and rsp_valid is registered from the last round.
// busy drops in the cycle the result is shown, so the next query may start then.
// rsp_valid is high for exactly one cycle and cannot be held off; the receiver must
// take rsp_reachable in that cycle. Rows must only be written while busy is low.
module graph_reachability_query (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [grq_pkg::NODE_W-1:0]      req_source_node,
   input  logic [grq_pkg::NODE_W-1:0]      req_target_node,
   output logic                            rsp_valid,
   output logic                            rsp_reachable,
   input  logic                            csr_write,
   input  logic [grq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [grq_pkg::ROW_W-1:0]       csr_data
);

   grq_pkg::cmd_type     cmd;
   grq_pkg::status_type  status;

   // sequencing of the search rounds
   grq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // rows, visited set and result
   grq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_source_node (req_source_node),
      .req_target_node (req_target_node),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_reachable   (rsp_reachable)
   );

`ifndef SYNTHESIS
   // a result only ends a search that was running
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("result without a running search");

   // an accepted transaction starts a search
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not start a search");

   // results never come back to back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in consecutive cycles");
`endif

endmodule

// File: tb/graph_reachability_query_tb.sv
module graph_reachability_query_tb;

   localparam int CLOCK_PERIOD = 20;
   localparam int REPORT_LIMIT = 10;
   localparam int CSR_TOP      = (1 << grq_pkg::CSR_INDEX_W) - 1;
   localparam int STRAY_SPAN   = CSR_TOP - grq_pkg::ROW_TOTAL + 1;

   // edge rows after reset: 1->2, 1->4, 2->5, 3->5, 3->6, 4->2, 5->4, 6->6
   localparam logic [grq_pkg::ROW_W-1:0] DEFAULT_ROWS [grq_pkg::ROW_TOTAL] =
      '{8'd0, 8'd20, 8'd32, 8'd96, 8'd4, 8'd16, 8'd64, 8'd0};

   typedef enum int {
      SPARSE_GRAPH,
      DENSE_GRAPH,
      CHAIN_GRAPH,
      SINGLE_EDGE_GRAPH
   } graph_style_type;

   typedef struct packed {
      logic [grq_pkg::NODE_W-1:0] source;
      logic [grq_pkg::NODE_W-1:0] target;
      logic                       reachable;
   } reach_answer_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic [grq_pkg::NODE_W-1:0]      req_source_node = '0;
   logic [grq_pkg::NODE_W-1:0]      req_target_node = '0;
   logic                            rsp_valid;
   logic                            rsp_reachable;
   logic                            csr_write = 1'b0;
   logic [grq_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [grq_pkg::ROW_W-1:0]       csr_data = '0;

   // graph as the block should hold it, and the next graph to be loaded
   logic [grq_pkg::ROW_W-1:0] model_rows [grq_pkg::ROW_TOTAL];
   logic [grq_pkg::ROW_W-1:0] graph_rows [grq_pkg::ROW_TOTAL];

   reach_answer_type pending_answers [$];

   int fault_count     = 0;
   int answers_checked = 0;
   int reachable_count = 0;
   int graphs_loaded   = 0;
   int gap_odds        = 0;

   // clock
   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   graph_reachability_query uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_source_node (req_source_node),
      .req_target_node (req_target_node),
      .rsp_valid       (rsp_valid),
      .rsp_reachable   (rsp_reachable),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // grow the reached set from the source round by round, then look up the target
   function automatic logic predict_reachable(input logic [grq_pkg::NODE_W-1:0] src,
                                              input logic [grq_pkg::NODE_W-1:0] dst);
      logic [grq_pkg::ROW_W-1:0] live;
      logic [grq_pkg::ROW_W-1:0] reached;
      logic [grq_pkg::ROW_W-1:0] grown;
      int                        k;
      int                        round;
      live = '0;
      for (k = 0; k < grq_pkg::NODE_COUNT; k++) live[k] = 1'b1;
      if (int'(src) >= grq_pkg::NODE_COUNT || int'(dst) >= grq_pkg::NODE_COUNT) return 1'b0;
      reached      = '0;
      reached[src] = 1'b1;
      for (round = 0; round < grq_pkg::NODE_COUNT; round++) begin
         grown = reached;
         for (k = 0; k < grq_pkg::NODE_COUNT && k < grq_pkg::ROW_TOTAL; k++) begin
            if (reached[k]) grown = grown | model_rows[k];
         end
         grown = grown & live;
         if (grown == reached) break;
         reached = grown;
      end
      return reached[dst];
   endfunction

   // result checking, prediction of accepted transactions and register tracking
   always @(posedge clock) begin : answer_check
      reach_answer_type want;
      if (reset) begin
         model_rows = DEFAULT_ROWS;
         pending_answers.delete();
      end else begin
         // each result against the oldest answer waiting
         if (rsp_valid) begin
            if (pending_answers.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("unexpected result: reachable %0b with no query waiting",
                           rsp_reachable);
            end else begin
               want = pending_answers.pop_front();
               answers_checked++;
               if (rsp_reachable !== want.reachable) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT)
                     $display("mismatch: %0d -> %0d expected reachable %0b, got %0b",
                              want.source, want.target, want.reachable, rsp_reachable);
               end
            end
         end
         // transaction taken at this edge
         if (start && !busy) begin
            want.source    = req_source_node;
            want.target    = req_target_node;
            want.reachable = predict_reachable(req_source_node, req_target_node);
            if (want.reachable) reachable_count++;
            pending_answers.push_back(want);
         end
         // row writes; indexes past the last row are dropped
         if (csr_write && int'(csr_index) < grq_pkg::ROW_TOTAL)
            model_rows[csr_index[grq_pkg::ROW_INDEX_W-1:0]] = csr_data;
      end
   end

   // offer one query and hold it until taken, then maybe idle for a burst
   task automatic send_query(input logic [grq_pkg::NODE_W-1:0] src,
                             input logic [grq_pkg::NODE_W-1:0] dst);
      start           <= 1'b1;
      req_source_node <= src;
      req_target_node <= dst;
      do @(posedge clock); while (busy);
      if (gap_odds > 0 && $urandom_range(1, 100) <= gap_odds) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // drop start and wait until every answer is in and the block is idle
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0 || busy);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input int idx, input logic [grq_pkg::ROW_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= grq_pkg::CSR_INDEX_W'(idx);
      csr_data  <= val;
      @(posedge clock);
   endtask

   // all rows in order, then writes to indexes past the last row
   task automatic load_graph(input int strays, input logic [grq_pkg::ROW_W-1:0] stray_ones);
      int k;
      int offset;
      offset = $urandom_range(0, STRAY_SPAN - 1);
      for (k = 0; k < grq_pkg::ROW_TOTAL; k++) write_reg(k, graph_rows[k]);
      for (k = 0; k < strays; k++)
         write_reg(grq_pkg::ROW_TOTAL + (k + offset) % STRAY_SPAN,
                   grq_pkg::ROW_W'($urandom) | stray_ones);
      csr_write <= 1'b0;
      graphs_loaded++;
   endtask

   task automatic build_graph(input graph_style_type style);
      int order [grq_pkg::NODE_COUNT];
      int k;
      int j;
      int swap;
      for (k = 0; k < grq_pkg::ROW_TOTAL; k++) graph_rows[k] = '0;
      case (style)
         SPARSE_GRAPH: begin
            for (k = 0; k < grq_pkg::ROW_TOTAL; k++)
               for (j = 0; j < grq_pkg::ROW_W; j++)
                  graph_rows[k][j] = ($urandom_range(0, 5) == 0);
         end
         DENSE_GRAPH: begin
            for (k = 0; k < grq_pkg::ROW_TOTAL; k++) graph_rows[k] = grq_pkg::ROW_W'($urandom);
         end
         CHAIN_GRAPH: begin
            // random visiting order, so deep searches start anywhere
            for (k = 0; k < grq_pkg::NODE_COUNT; k++) order[k] = k;
            for (k = grq_pkg::NODE_COUNT - 1; k > 0; k--) begin
               j        = $urandom_range(0, k);
               swap     = order[k];
               order[k] = order[j];
               order[j] = swap;
            end
            for (k = 0; k < grq_pkg::NODE_COUNT - 1; k++)
               graph_rows[order[k]][order[k + 1]] = 1'b1;
            if ($urandom_range(0, 1))
               graph_rows[$urandom_range(0, grq_pkg::ROW_TOTAL - 1)]
                         [$urandom_range(0, grq_pkg::ROW_W - 1)] = 1'b1;
         end
         SINGLE_EDGE_GRAPH: begin
            for (k = 0; k < grq_pkg::ROW_TOTAL; k++)
               if ($urandom_range(0, 3) != 0)
                  graph_rows[k][$urandom_range(0, grq_pkg::ROW_W - 1)] = 1'b1;
         end
         default: begin
         end
      endcase
   endtask

   // graph loaded by reset: hits, misses, self queries and the self loop
   task automatic test_default_graph();
      send_query(1, 5);
      send_query(1, 6);
      send_query(3, 4);
      send_query(6, 6);
      send_query(0, 0);
      send_query(0, 7);
      send_query(7, 7);
      send_query(7, 0);
      send_query(4, 4);
      send_query(2, 1);
      send_query(3, 2);
      send_query(5, 3);
      settle();
   endtask

   // no edges, every edge, the longest chain and a full ring
   task automatic test_edge_extremes();
      int k;
      gap_odds = 25;
      // no edges, and all-ones writes to every index past the last row
      for (k = 0; k < grq_pkg::ROW_TOTAL; k++) graph_rows[k] = '0;
      load_graph(STRAY_SPAN, '1);
      send_query(0, 1);
      send_query(3, 3);
      send_query(0, 7);
      settle();
      for (k = 0; k < grq_pkg::ROW_TOTAL; k++) graph_rows[k] = '1;
      load_graph(0, '0);
      send_query(7, 0);
      send_query(0, 7);
      send_query(5, 2);
      settle();
      // chain 0->1->...->7 needs every expansion round
      for (k = 0; k < grq_pkg::ROW_TOTAL; k++)
         graph_rows[k] = (k < grq_pkg::NODE_COUNT - 1) ? grq_pkg::ROW_W'(1) << (k + 1) : '0;
      load_graph(0, '0);
      send_query(0, 7);
      send_query(7, 0);
      send_query(3, 7);
      settle();
      for (k = 0; k < grq_pkg::ROW_TOTAL; k++)
         graph_rows[k] = grq_pkg::ROW_W'(1) << ((k + 1) % grq_pkg::NODE_COUNT);
      load_graph(0, '0);
      send_query(7, 6);
      send_query(1, 0);
      settle();
   endtask

   // many random graphs of each shape with random queries and sender gaps
   task automatic test_random_graphs();
      int phase;
      for (phase = 0; phase < 14; phase++) begin
         gap_odds = (phase % 3 == 0) ? 0 : $urandom_range(10, 60);
         build_graph(graph_style_type'(phase % 4));
         load_graph($urandom_range(0, 2), '0);
         repeat (110)
            send_query(grq_pkg::NODE_W'($urandom), grq_pkg::NODE_W'($urandom));
         settle();
      end
   endtask

   // queries offered back to back with no gaps at all
   task automatic test_back_to_back();
      gap_odds = 0;
      build_graph(SPARSE_GRAPH);
      load_graph(1, '0);
      repeat (200) send_query(grq_pkg::NODE_W'($urandom), grq_pkg::NODE_W'($urandom));
   endtask

   // test sequence
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_default_graph();
      test_edge_extremes();
      test_random_graphs();
      test_back_to_back();
      settle();
      repeat (12) @(posedge clock);
      if (pending_answers.size() != 0) begin
         fault_count += pending_answers.size();
         $display("%0d queries never answered", pending_answers.size());
      end
      $display("%0d queries answered over the reset graph and %0d loaded graphs",
               answers_checked, graphs_loaded);
      $display("%0d predicted reachable, %0d predicted unreachable, %0d faults",
               reachable_count, answers_checked - reachable_count, fault_count);
      if (fault_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(CLOCK_PERIOD * 400000);
      $display("run timed out");
      $display("Test completed with failures");
      $finish;
   end

endmodule
